// File: rtl/core/mfq_pkg.sv
// Shared constants and helpers for the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mfq_pkg;
    localparam int CAPACITY = 64;
    localparam int LEVELS   = 3;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LVL_W    = 2;
    localparam int PID_W    = 16;
    localparam int AGE_W    = 10;
    localparam int QNT_W    = 8;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_NEXT = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM0  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM2  = 2'd3;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 10'd999;
    localparam logic [QNT_W-1:0] QUANTUM0_RST  = 8'd0;
    localparam logic [QNT_W-1:0] QUANTUM1_RST  = 8'd4;
    localparam logic [QNT_W-1:0] QUANTUM2_RST  = 8'd1;

    localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(LEVELS - 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LVL_W-1:0] lvl_t;

    // Successor of an entry on the free list as it stands after reset.
    function automatic idx_t reset_link(input idx_t i);
        if (i == IDX_W'(CAPACITY - 1))
            reset_link = '0;
        else
            reset_link = i + idx_t'(1);
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/mfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/multilevel_feedback_queue_scheduler.sv
// Top level: three-level feedback queue scheduler over a shared linked-list store.
// A tick walks every entry of levels 1 and 2 in turn; once the result is staged and sent,
// the block returns to idle before the next request is taken.
// One request is in work at a time; the store has a single read port.
// Reset empties all queues, chains the free list in order through per-entry valid bits
// and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_feedback_queue_scheduler
    import mfq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [OP_W-1:0]      opcode,
    input  wire logic [PID_W-1:0]     process_id,
    input  wire logic [LVL_W-1:0]     level,
    input  wire logic [AGE_W-1:0]     start_age,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      granted,
    output logic [PID_W-1:0]          out_process_id,
    output logic [LVL_W-1:0]          out_level,
    output logic [AGE_W-1:0]          out_age,
    output logic [QNT_W-1:0]          quantum,
    output logic                      accepted,
    output logic                      any_waiting
);
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ADD_WB  = 3'd1;
    localparam logic [2:0] S_NEXT_WB = 3'd2;
    localparam logic [2:0] S_TICK_RD = 3'd3;
    localparam logic [2:0] S_TICK_WB = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [AGE_W-1:0] age_limit_reg;
    logic [QNT_W-1:0] q0_reg, q1_reg, q2_reg;

    idx_t head_reg [LEVELS];
    idx_t head_next [LEVELS];
    idx_t tail_reg [LEVELS];
    idx_t tail_next [LEVELS];
    cnt_t count_reg [LEVELS];
    cnt_t count_next [LEVELS];
    idx_t free_head_reg, free_head_next;
    cnt_t free_count_reg, free_count_next;
    logic [CAPACITY-1:0] link_valid_reg, link_valid_next;

    // request work registers
    logic [PID_W-1:0] pid_reg, pid_next;
    logic [AGE_W-1:0] sage_reg, sage_next;
    lvl_t lvl_reg, lvl_next;
    cnt_t tn_reg, tn_next;
    cnt_t tk_reg, tk_next;

    // result staging
    logic             res_granted_reg, res_granted_next;
    logic [PID_W-1:0] res_pid_reg, res_pid_next;
    lvl_t             res_lvl_reg, res_lvl_next;
    logic [AGE_W-1:0] res_age_reg, res_age_next;
    logic [QNT_W-1:0] res_q_reg, res_q_next;
    logic             res_acc_reg, res_acc_next;

    logic out_valid_reg;
    logic             o_granted_reg;
    logic [PID_W-1:0] o_pid_reg;
    lvl_t             o_lvl_reg;
    logic [AGE_W-1:0] o_age_reg;
    logic [QNT_W-1:0] o_q_reg;
    logic             o_acc_reg;
    logic             o_any_reg;

    // store ports
    idx_t raddr;
    idx_t rd_addr_reg;
    logic rd_lv_reg;
    logic [IDX_W-1:0] link_rdata;
    logic [PID_W-1:0] proc_rdata;
    logic [AGE_W-1:0] age_rdata;
    logic             link_we, proc_we, age_we;
    idx_t             link_waddr, proc_waddr, age_waddr;
    idx_t             link_wdata;
    logic [AGE_W-1:0] age_wdata;
    idx_t             link_data;

    logic in_accept;
    logic out_free;
    logic any_busy;
    lvl_t first_lvl;
    logic first_found;
    idx_t idx;
    lvl_t dst;

    function automatic logic [QNT_W-1:0] level_quantum(input lvl_t l,
        input logic [QNT_W-1:0] a, input logic [QNT_W-1:0] b, input logic [QNT_W-1:0] c);
        case (l)
            2'd0:    level_quantum = a;
            2'd1:    level_quantum = b;
            default: level_quantum = c;
        endcase
    endfunction

    mfq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(raddr), .rdata(link_rdata)
    );
    mfq_ram #(.WIDTH(PID_W), .DEPTH(CAPACITY)) u_proc (
        .clk(clk), .we(proc_we), .waddr(proc_waddr), .wdata(pid_reg),
        .raddr(raddr), .rdata(proc_rdata)
    );
    mfq_ram #(.WIDTH(AGE_W), .DEPTH(CAPACITY)) u_age (
        .clk(clk), .we(age_we), .waddr(age_waddr), .wdata(age_wdata),
        .raddr(raddr), .rdata(age_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign link_data = rd_lv_reg ? link_rdata : reset_link(rd_addr_reg);

    always_comb
    begin
        first_found = 1'b0;
        first_lvl   = '0;
        any_busy    = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                first_found = 1'b1;
                first_lvl   = LVL_W'(l);
                any_busy    = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        link_valid_next = link_valid_reg;
        pid_next        = pid_reg;
        sage_next       = sage_reg;
        lvl_next        = lvl_reg;
        tn_next         = tn_reg;
        tk_next         = tk_reg;
        res_granted_next = res_granted_reg;
        res_pid_next    = res_pid_reg;
        res_lvl_next    = res_lvl_reg;
        res_age_next    = res_age_reg;
        res_q_next      = res_q_reg;
        res_acc_next    = res_acc_reg;
        raddr           = head_reg[lvl_reg];
        link_we         = 1'b0;
        link_waddr      = '0;
        link_wdata      = '0;
        proc_we         = 1'b0;
        proc_waddr      = '0;
        age_we          = 1'b0;
        age_waddr       = '0;
        age_wdata       = sage_reg;
        idx             = rd_addr_reg;
        dst             = lvl_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_granted_next = 1'b0;
                    res_pid_next     = '0;
                    res_lvl_next     = '0;
                    res_age_next     = '0;
                    res_q_next       = '0;
                    res_acc_next     = 1'b0;
                    pid_next         = process_id;
                    sage_next        = start_age;
                    lvl_next         = level;
                    state_next       = S_DONE;
                    case (opcode)
                        OP_ADD:
                        begin
                            if (free_count_reg != '0 && level <= LAST_LEVEL)
                            begin
                                raddr      = free_head_reg;
                                state_next = S_ADD_WB;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (first_found)
                            begin
                                lvl_next   = first_lvl;
                                raddr      = head_reg[first_lvl];
                                state_next = S_NEXT_WB;
                            end
                        end
                        OP_TICK:
                        begin
                            lvl_next   = LVL_W'(1);
                            tn_next    = count_reg[1];
                            tk_next    = '0;
                            state_next = S_TICK_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ADD_WB:
            begin
                idx             = free_head_reg;
                free_head_next  = link_data;
                free_count_next = free_count_reg - cnt_t'(1);
                proc_we         = 1'b1;
                proc_waddr      = idx;
                age_we          = 1'b1;
                age_waddr       = idx;
                age_wdata       = sage_reg;
                if (count_reg[lvl_reg] != '0)
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg[lvl_reg];
                    link_wdata = idx;
                    link_valid_next[tail_reg[lvl_reg]] = 1'b1;
                end
                else
                begin
                    head_next[lvl_reg] = idx;
                end
                tail_next[lvl_reg]  = idx;
                count_next[lvl_reg] = count_reg[lvl_reg] + cnt_t'(1);
                res_acc_next        = 1'b1;
                state_next          = S_DONE;
            end
            S_NEXT_WB:
            begin
                head_next[lvl_reg]  = link_data;
                count_next[lvl_reg] = count_reg[lvl_reg] - cnt_t'(1);
                res_granted_next    = 1'b1;
                res_pid_next        = proc_rdata;
                res_lvl_next        = lvl_reg;
                res_age_next        = age_rdata;
                res_q_next          = level_quantum(lvl_reg, q0_reg, q1_reg, q2_reg);
                // return the entry to the free list
                link_we         = 1'b1;
                link_waddr      = idx;
                link_wdata      = free_head_reg;
                link_valid_next[idx] = 1'b1;
                free_head_next  = idx;
                free_count_next = free_count_reg + cnt_t'(1);
                state_next      = S_DONE;
            end
            S_TICK_RD:
            begin
                if (tk_reg == tn_reg)
                begin
                    if (lvl_reg == LAST_LEVEL)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + lvl_t'(1);
                        tn_next  = count_reg[lvl_reg + lvl_t'(1)];
                        tk_next  = '0;
                    end
                end
                else
                begin
                    raddr      = head_reg[lvl_reg];
                    state_next = S_TICK_WB;
                end
            end
            S_TICK_WB:
            begin
                // pop the head, then append it to its own level or the one above
                head_next[lvl_reg]  = link_data;
                count_next[lvl_reg] = count_reg[lvl_reg] - cnt_t'(1);
                age_we    = 1'b1;
                age_waddr = idx;
                if (age_rdata > age_limit_reg)
                begin
                    age_wdata = '0;
                    dst       = lvl_reg - lvl_t'(1);
                end
                else
                begin
                    age_wdata = (age_rdata == AGE_MAX) ? AGE_MAX : age_rdata + AGE_W'(1);
                    dst       = lvl_reg;
                end
                if (count_next[dst] != '0)
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg[dst];
                    link_wdata = idx;
                    link_valid_next[tail_reg[dst]] = 1'b1;
                end
                else
                begin
                    head_next[dst] = idx;
                end
                tail_next[dst]  = idx;
                count_next[dst] = count_next[dst] + cnt_t'(1);
                tk_next         = tk_reg + cnt_t'(1);
                state_next      = S_TICK_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            age_limit_reg  <= AGE_LIMIT_RST;
            q0_reg         <= QUANTUM0_RST;
            q1_reg         <= QUANTUM1_RST;
            q2_reg         <= QUANTUM2_RST;
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            free_head_reg  <= '0;
            free_count_reg <= cnt_t'(CAPACITY);
            link_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            link_valid_reg <= link_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AGE_LIMIT: age_limit_reg <= cfg_data;
                    REG_QUANTUM0:  q0_reg <= cfg_data[QNT_W-1:0];
                    REG_QUANTUM1:  q1_reg <= cfg_data[QNT_W-1:0];
                    REG_QUANTUM2:  q2_reg <= cfg_data[QNT_W-1:0];
                    default:       age_limit_reg <= age_limit_reg;
                endcase
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg         <= pid_next;
        sage_reg        <= sage_next;
        lvl_reg         <= lvl_next;
        tn_reg          <= tn_next;
        tk_reg          <= tk_next;
        res_granted_reg <= res_granted_next;
        res_pid_reg     <= res_pid_next;
        res_lvl_reg     <= res_lvl_next;
        res_age_reg     <= res_age_next;
        res_q_reg       <= res_q_next;
        res_acc_reg     <= res_acc_next;
        rd_addr_reg     <= raddr;
        rd_lv_reg       <= link_valid_reg[raddr];
        if (state_reg == S_DONE && out_free)
        begin
            o_granted_reg <= res_granted_reg;
            o_pid_reg     <= res_pid_reg;
            o_lvl_reg     <= res_lvl_reg;
            o_age_reg     <= res_age_reg;
            o_q_reg       <= res_q_reg;
            o_acc_reg     <= res_acc_reg;
            o_any_reg     <= any_busy;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted        = o_granted_reg;
    assign out_process_id = o_pid_reg;
    assign out_level      = o_lvl_reg;
    assign out_age        = o_age_reg;
    assign quantum        = o_q_reg;
    assign accepted       = o_acc_reg;
    assign any_waiting    = o_any_reg;
endmodule
`default_nettype wire
